// ----- rtl/mdbs_pkg.sv -----
// shared constants, control word types and microprogram of the dual shelf biquad
`default_nettype none

package mdbs_pkg;

  // sizes of the datapath
  localparam int CHANNELS       = 8;
  localparam int CH_W           = 3;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 5;
  localparam int GAIN_W         = 17;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int WORD_W         = 32;
  localparam int WORDS_PER_CH   = 8;
  localparam int WIDX_W         = 3;
  localparam int MEM_DEPTH      = CHANNELS * WORDS_PER_CH;
  localparam int MEM_AW         = CH_W + WIDX_W;
  localparam int MUL_W          = WORD_W + COEF_W;
  localparam int ACC_W          = MUL_W + 3;
  localparam int ACT_W          = 4;
  localparam int FF_W           = 3 * COEF_W;
  localparam int FB_W           = 2 * COEF_W;
  localparam int TD_W           = ((CH_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_DW         = 64;
  localparam int CFG_AW         = 6;
  localparam int PC_W           = 4;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_BYPASS = 3'd0,
    REG_ACTIVE = 3'd1,
    REG_GAIN   = 3'd2,
    REG_LFF    = 3'd3,
    REG_LFB    = 3'd4,
    REG_HFF    = 3'd5,
    REG_HFB    = 3'd6
  } reg_idx_t;

  // delay word places inside a channel row
  localparam logic [WIDX_W-1:0] WD_LX1 = WIDX_W'(0);
  localparam logic [WIDX_W-1:0] WD_LX2 = WIDX_W'(1);
  localparam logic [WIDX_W-1:0] WD_LY1 = WIDX_W'(2);
  localparam logic [WIDX_W-1:0] WD_LY2 = WIDX_W'(3);
  localparam logic [WIDX_W-1:0] WD_HX1 = WIDX_W'(4);
  localparam logic [WIDX_W-1:0] WD_HX2 = WIDX_W'(5);
  localparam logic [WIDX_W-1:0] WD_HY1 = WIDX_W'(6);
  localparam logic [WIDX_W-1:0] WD_HY2 = WIDX_W'(7);

  // multiplier operand selects
  typedef enum logic [1:0] {
    A_SMP = 2'd0,
    A_V   = 2'd1,
    A_RD  = 2'd2
  } asel_t;

  typedef enum logic [2:0] {
    B_GAIN = 3'd0,
    B_B0   = 3'd1,
    B_B1   = 3'd2,
    B_B2   = 3'd3,
    B_A1   = 3'd4,
    B_A2   = 3'd5
  } bsel_t;

  // accumulator operation on the registered product
  typedef enum logic [1:0] {
    ACC_NOP  = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } accop_t;

  // delay memory write data selects
  typedef enum logic [1:0] {
    W_RD  = 2'd0,
    W_V   = 2'd1,
    W_RND = 2'd2
  } wsel_t;

  // sequencing of the step counter
  typedef enum logic [1:0] {
    NX_NEXT    = 2'd0,
    NX_PASSCHK = 2'd1,
    NX_DONE    = 2'd2
  } nx_t;

  typedef struct packed {
    logic              rd_en;
    logic [WIDX_W-1:0] rd_word;
    logic              mul_en;
    asel_t             a_sel;
    bsel_t             b_sel;
    logic              hi;
    accop_t            acc_op;
    logic              rnd_en;
    logic              rnd_gain;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_word;
    wsel_t             w_sel;
    nx_t               nx;
  } ctl_t;

  // sequencer to datapath
  typedef struct packed {
    logic busy;
    logic go;
    logic fin;
    ctl_t ctl;
  } seq_t;

  localparam ctl_t CTL_NOP = '{
    rd_en: 1'b0, rd_word: WD_LX1, mul_en: 1'b0, a_sel: A_SMP, b_sel: B_GAIN,
    hi: 1'b0, acc_op: ACC_NOP, rnd_en: 1'b0, rnd_gain: 1'b0, wr_en: 1'b0,
    wr_word: WD_LX1, w_sel: W_RD, nx: NX_NEXT
  };

  // microprogram: preamp, low shelf, high shelf, output
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = CTL_NOP;
    case (pc)
      4'd0: begin
        c.rd_en = 1'b1; c.rd_word = WD_LX1;
        c.mul_en = 1'b1; c.a_sel = A_SMP; c.b_sel = B_GAIN;
        c.nx = NX_PASSCHK;
      end
      4'd1: begin
        c.rd_en = 1'b1; c.rd_word = WD_LX2;
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_B1;
        c.acc_op = ACC_LOAD;
        c.wr_en = 1'b1; c.wr_word = WD_LX2; c.w_sel = W_RD;
      end
      4'd2: begin
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_B2;
        c.acc_op = ACC_LOAD;
        c.rnd_en = 1'b1; c.rnd_gain = 1'b1;
      end
      4'd3: begin
        c.rd_en = 1'b1; c.rd_word = WD_LY1;
        c.mul_en = 1'b1; c.a_sel = A_V; c.b_sel = B_B0;
        c.acc_op = ACC_ADD;
        c.wr_en = 1'b1; c.wr_word = WD_LX1; c.w_sel = W_V;
      end
      4'd4: begin
        c.rd_en = 1'b1; c.rd_word = WD_LY2;
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_A1;
        c.acc_op = ACC_ADD;
        c.wr_en = 1'b1; c.wr_word = WD_LY2; c.w_sel = W_RD;
      end
      4'd5: begin
        c.rd_en = 1'b1; c.rd_word = WD_HX1;
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_A2;
        c.acc_op = ACC_SUB;
      end
      4'd6: begin
        c.rd_en = 1'b1; c.rd_word = WD_HX2;
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_B1; c.hi = 1'b1;
        c.acc_op = ACC_SUB;
        c.wr_en = 1'b1; c.wr_word = WD_HX2; c.w_sel = W_RD;
      end
      4'd7: begin
        c.rd_en = 1'b1; c.rd_word = WD_HY1;
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_B2; c.hi = 1'b1;
        c.acc_op = ACC_LOAD;
        c.rnd_en = 1'b1;
        c.wr_en = 1'b1; c.wr_word = WD_LY1; c.w_sel = W_RND;
      end
      4'd8: begin
        c.rd_en = 1'b1; c.rd_word = WD_HY2;
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_A1; c.hi = 1'b1;
        c.acc_op = ACC_ADD;
        c.wr_en = 1'b1; c.wr_word = WD_HY2; c.w_sel = W_RD;
      end
      4'd9: begin
        c.mul_en = 1'b1; c.a_sel = A_RD; c.b_sel = B_A2; c.hi = 1'b1;
        c.acc_op = ACC_SUB;
        c.wr_en = 1'b1; c.wr_word = WD_HX1; c.w_sel = W_V;
      end
      4'd10: begin
        c.mul_en = 1'b1; c.a_sel = A_V; c.b_sel = B_B0; c.hi = 1'b1;
        c.acc_op = ACC_SUB;
      end
      4'd11: begin
        c.acc_op = ACC_ADD;
      end
      4'd12: begin
        c.rnd_en = 1'b1;
        c.wr_en = 1'b1; c.wr_word = WD_HY1; c.w_sel = W_RND;
      end
      4'd13: begin
        c.nx = NX_DONE;
      end
      default: begin
        c.nx = NX_DONE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/multichannel_dual_biquad_shelf.sv -----
// top level: config registers, multiply-accumulate datapath, delay memory and output register
// A filtered item runs 14 microcode steps after it is accepted before it is in the output
// register; a passthrough item (bypass or inactive channel) finishes at the first step.
// A finishing step stalls while an untaken result holds the output register. A new item is
// accepted only when the last has finished (one 32x21 multiplier, 1r1w delay memory).
// Reset (rst_n, synchronous, active low): bypass on, 8 active channels, unity gain, zero
// coefficients; per-channel row valid bits make all delay words read as zero, no sweep.
`default_nettype none

module multichannel_dual_biquad_shelf import mdbs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [TD_W-1:0]   in_tdata,   // channel[2:0], sample[26:3], zero pad
  input  wire logic              in_tlast,   // block_end
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [TD_W-1:0]   out_tdata,  // out_channel[2:0], out_sample[26:3], zero pad
  output logic                   out_tuser,  // railed
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  // configuration registers
  logic              bypass_r;
  logic [ACT_W-1:0]  act_r;
  logic [GAIN_W-1:0] gain_r;
  logic [FF_W-1:0]   lff_r, hff_r;
  logic [FB_W-1:0]   lfb_r, hfb_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  // item and datapath registers
  logic [CH_W-1:0]               ch_r;
  logic [SAMPLE_BITS-1:0]        x_r;
  logic                          last_r;
  logic signed [WORD_W-1:0]      v_r;
  logic signed [MUL_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [CHANNELS-1:0]           valid_r;
  logic [CHANNELS-1:0]           railed_r;

  // output register
  logic                   out_valid_r;
  logic [CH_W-1:0]        out_ch_r;
  logic [SAMPLE_BITS-1:0] out_smp_r;
  logic                   out_rail_r;

  seq_t                     seq;
  logic                     in_acc;
  logic                     pass_c;
  logic                     hold_c;
  logic                     fin_go;
  logic                     pass_fin;
  logic [WORD_W-1:0]        rd_raw;
  logic signed [WORD_W-1:0] rdv;
  logic signed [WORD_W-1:0] a_op;
  logic signed [COEF_W-1:0] b_op;
  logic [FF_W-1:0]          ff_sel;
  logic [FB_W-1:0]          fb_sel;
  logic signed [ACC_W:0]    acc_x, sum_g, sum_c, sh_g, sh_c, rnd_pre;
  logic [ACC_W-WORD_W+1:0]  rnd_top;
  logic [WORD_W-1:0]        rnd_c;
  logic                     ram_we, ram_re;
  logic [WORD_W-1:0]        ram_wd;
  logic [MEM_AW-1:0]        ram_wa, ram_ra;
  logic [WORD_W-SAMPLE_BITS:0] smp_top;
  logic                     smp_rail;
  logic [SAMPLE_BITS-1:0]   smp_sat;
  logic                     flag_now;
  logic signed [ACC_W-1:0]  prod_x;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b1;
      act_r    <= ACT_W'(CHANNELS);
      gain_r   <= GAIN_W'(1) << GAIN_FRAC_BITS;
      lff_r    <= '0;
      lfb_r    <= '0;
      hff_r    <= '0;
      hfb_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BYPASS: bypass_r <= cfg_pwdata[0];
        REG_ACTIVE: act_r    <= cfg_pwdata[ACT_W-1:0];
        REG_GAIN:   gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_LFF:    lff_r    <= cfg_pwdata[FF_W-1:0];
        REG_LFB:    lfb_r    <= cfg_pwdata[FB_W-1:0];
        REG_HFF:    hff_r    <= cfg_pwdata[FF_W-1:0];
        REG_HFB:    hfb_r    <= cfg_pwdata[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_BYPASS: cfg_prdata = CFG_DW'(bypass_r);
      REG_ACTIVE: cfg_prdata = CFG_DW'(act_r);
      REG_GAIN:   cfg_prdata = CFG_DW'(gain_r);
      REG_LFF:    cfg_prdata = CFG_DW'(lff_r);
      REG_LFB:    cfg_prdata = CFG_DW'(lfb_r);
      REG_HFF:    cfg_prdata = CFG_DW'(hff_r);
      REG_HFB:    cfg_prdata = CFG_DW'(hfb_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // input handshake and item capture
  assign in_tready = !seq.busy;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= in_tdata[CH_W-1:0];
      x_r    <= in_tdata[CH_W+SAMPLE_BITS-1:CH_W];
      last_r <= in_tlast;
    end
  end

  // sequencer
  assign pass_c = bypass_r | ({{(ACT_W-CH_W){1'b0}}, ch_r} >= act_r);
  assign hold_c = out_valid_r & ~out_tready;

  mdbs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_acc),
    .pass_i  (pass_c),
    .hold_i  (hold_c),
    .seq_o   (seq)
  );

  assign fin_go   = seq.go & seq.fin;
  assign pass_fin = seq.ctl.nx == NX_PASSCHK;

  // delay memory, rows not yet written read as zero
  assign rdv = valid_r[ch_r] ? rd_raw : '0;

  // multiplier operands
  assign ff_sel = seq.ctl.hi ? hff_r : lff_r;
  assign fb_sel = seq.ctl.hi ? hfb_r : lfb_r;

  always_comb begin
    case (seq.ctl.a_sel)
      A_SMP:   a_op = {{(WORD_W-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
      A_V:     a_op = v_r;
      A_RD:    a_op = rdv;
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (seq.ctl.b_sel)
      B_GAIN:  b_op = {{(COEF_W-GAIN_W){1'b0}}, gain_r};
      B_B0:    b_op = ff_sel[COEF_W-1:0];
      B_B1:    b_op = ff_sel[2*COEF_W-1:COEF_W];
      B_B2:    b_op = ff_sel[3*COEF_W-1:2*COEF_W];
      B_A1:    b_op = fb_sel[COEF_W-1:0];
      B_A2:    b_op = fb_sel[2*COEF_W-1:COEF_W];
      default: b_op = '0;
    endcase
  end

  // rounding shift of the accumulator and saturation to a delay word
  assign acc_x   = {acc_r[ACC_W-1], acc_r};
  assign sum_g   = acc_x + ((ACC_W+1)'(1) << (GAIN_FRAC_BITS - 1));
  assign sum_c   = acc_x + ((ACC_W+1)'(1) << (COEF_FRAC_BITS - 1));
  assign sh_g    = sum_g >>> GAIN_FRAC_BITS;
  assign sh_c    = sum_c >>> COEF_FRAC_BITS;
  assign rnd_pre = seq.ctl.rnd_gain ? sh_g : sh_c;
  assign rnd_top = rnd_pre[ACC_W:WORD_W-1];

  always_comb begin
    if ((&rnd_top) | ~(|rnd_top)) begin
      rnd_c = rnd_pre[WORD_W-1:0];
    end else if (rnd_pre[ACC_W]) begin
      rnd_c = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      rnd_c = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  // multiply, accumulate, round
  assign prod_x = {{(ACC_W-MUL_W){prod_r[MUL_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (seq.go) begin
      if (seq.ctl.mul_en) begin
        prod_r <= a_op * b_op;
      end
      case (seq.ctl.acc_op)
        ACC_LOAD: acc_r <= prod_x;
        ACC_ADD:  acc_r <= acc_r + prod_x;
        ACC_SUB:  acc_r <= acc_r - prod_x;
        default: ;
      endcase
      if (seq.ctl.rnd_en) begin
        v_r <= rnd_c;
      end
    end
  end

  // delay memory port control
  always_comb begin
    case (seq.ctl.w_sel)
      W_RD:    ram_wd = rdv;
      W_V:     ram_wd = v_r;
      W_RND:   ram_wd = rnd_c;
      default: ram_wd = '0;
    endcase
  end

  assign ram_we = seq.go & seq.ctl.wr_en;
  assign ram_re = seq.go & seq.ctl.rd_en;
  assign ram_wa = {ch_r, seq.ctl.wr_word};
  assign ram_ra = {ch_r, seq.ctl.rd_word};

  mdbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_delay_ram (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .re_i    (ram_re),
    .raddr_i (ram_ra),
    .rdata_o (rd_raw)
  );

  // saturation to the sample range
  assign smp_top  = v_r[WORD_W-1:SAMPLE_BITS-1];
  assign smp_rail = ~((&smp_top) | ~(|smp_top));

  always_comb begin
    if (!smp_rail) begin
      smp_sat = v_r[SAMPLE_BITS-1:0];
    end else if (v_r[WORD_W-1]) begin
      smp_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      smp_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // railed flags and row valid bits, a railed block end drops the row
  assign flag_now = railed_r[ch_r] | smp_rail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      railed_r <= '0;
    end else if (fin_go) begin
      if (pass_fin) begin
        if (last_r) begin
          railed_r[ch_r] <= 1'b0;
        end
      end else if (last_r) begin
        railed_r[ch_r] <= 1'b0;
        valid_r[ch_r]  <= ~flag_now;
      end else begin
        railed_r[ch_r] <= flag_now;
        valid_r[ch_r]  <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tvalid & out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_ch_r <= ch_r;
      if (pass_fin) begin
        out_smp_r  <= x_r;
        out_rail_r <= 1'b0;
      end else begin
        out_smp_r  <= smp_sat;
        out_rail_r <= smp_rail;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TD_W-CH_W-SAMPLE_BITS){1'b0}}, out_smp_r, out_ch_r};
  assign out_tuser  = out_rail_r;

  // a railed result sits at one of the sample limits
  a_rail_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rail_r) |->
      (out_smp_r == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
       out_smp_r == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("railed result not at a sample limit");

  // the delay memory is written only while an item is in the program
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> seq.busy)
    else $error("delay memory written while idle");

  // a result appears only from a finishing step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_go))
    else $error("result without a finishing step");

  // a block end always leaves the channel's railed flag clear
  a_block_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && last_r) |=> !railed_r[$past(ch_r)])
    else $error("railed flag survived a block end");

endmodule

`default_nettype wire

// ----- rtl/mdbs_ram.sv -----
// generic single write port ram with registered read, read-first on a shared address
`default_nettype none

module mdbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // storage write
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata_r <= mem_r[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/mdbs_seq.sv -----
// microcode sequencer: step counter, control store and finish/stall decision
`default_nettype none

module mdbs_seq import mdbs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start_i,
  input  wire logic pass_i,
  input  wire logic hold_i,
  output seq_t      seq_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ctl_t            ctl;
  logic            fin;
  logic            go;

  // control word of the current step
  assign ctl = ucode(pc_r);
  assign fin = (ctl.nx == NX_DONE) || ((ctl.nx == NX_PASSCHK) && pass_i);
  assign go  = (state_r == ST_RUN) && !(fin && hold_i);

  // next step
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          state_nxt = ST_RUN;
          pc_nxt    = '0;
        end
      end
      ST_RUN: begin
        if (go) begin
          if (fin) begin
            state_nxt = ST_IDLE;
          end else begin
            pc_nxt = pc_r + PC_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign seq_o = '{busy: (state_r == ST_RUN), go: go, fin: fin, ctl: ctl};

endmodule

`default_nettype wire
